>>> rtl/rtf_html_deencapsulator_top_defines.svh
// Assertion macros shared by the checker.
`ifndef RTF_HTML_DEENCAPSULATOR_TOP_DEFINES_SVH
`define RTF_HTML_DEENCAPSULATOR_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define RHD_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, checked in and out of reset.
`define RHD_ASSERT_NEXT(label, clk, a, c) \
    label: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("assertion failed");

`endif

>>> rtl/rhd_pkg.sv
package rhd_pkg;

    localparam int WINDOW_BYTES = 11;
    localparam int TAG_BITS     = 16;
    localparam int MATCH_BYTES  = 11;
    localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);
    localparam int IDX_W        = $clog2(WINDOW_BYTES);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_word;

    typedef logic [WINDOW_BYTES-1:0][7:0] t_window;
    typedef logic [MATCH_BYTES-1:0][7:0]  t_pattern;

    typedef enum logic [3:0] {
        MODE_SEEK      = 4'd0,
        MODE_NORMAL    = 4'd1,
        MODE_TAGNUM    = 4'd2,
        MODE_SKIPBRACE = 4'd3,
        MODE_DIGITS    = 4'd4,
        MODE_PNTEXT    = 4'd5,
        MODE_HTMLRTF   = 4'd6
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_EMIT,
        ST_TERM
    } t_state;

    // Patterns are left-justified: first character in the top byte.
    localparam t_pattern P_HTMLTAG_OPEN = "{\\*\\htmltag";
    localparam t_pattern P_HTMLTAG      = {"\\*\\htmltag", 8'h00};
    localparam t_pattern P_MHTMLTAG     = "\\*\\mhtmltag";
    localparam t_pattern P_PAR          = {"\\par", 56'h0};
    localparam t_pattern P_TAB          = {"\\tab", 56'h0};
    localparam t_pattern P_LINE         = {"\\line", 48'h0};
    localparam t_pattern P_LI           = {"\\li", 64'h0};
    localparam t_pattern P_FI           = {"\\fi-", 56'h0};
    localparam t_pattern P_HEX          = {"\\'", 72'h0};
    localparam t_pattern P_PNTEXT       = {"\\pntext", 32'h0};
    localparam t_pattern P_HTMLRTF      = {"\\htmlrtf", 24'h0};
    localparam t_pattern P_HTMLRTF0     = {"\\htmlrtf0", 16'h0};
    localparam t_pattern P_LBRACE       = {"\\{", 72'h0};
    localparam t_pattern P_RBRACE       = {"\\}", 72'h0};

    function automatic logic f_match(t_window w, logic [FILL_W-1:0] fill,
                                     t_pattern pat, logic [FILL_W-1:0] n);
        logic ok;
        ok = (fill >= n);
        for (int i = 0; i < MATCH_BYTES; i++) begin
            if (i < int'(n) && w[i] != pat[MATCH_BYTES-1-i]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // Escape digit value, lenient letter rule; absent bytes read as zero,
    // other bytes keep their raw code.
    function automatic logic [7:0] f_hex(logic [7:0] b, logic present);
        logic [7:0] v;
        v = b;
        if (!present) begin
            v = 8'd0;
        end else if (b >= "0" && b <= "9") begin
            v = b - 8'd48;
        end else if (b >= "A" && b <= "Z") begin
            v = b - 8'd55;
        end else if (b >= "a" && b <= "z") begin
            v = b - 8'd87;
        end
        return v;
    endfunction

endpackage

>>> rtl/rtf_html_deencapsulator_top.sv
// Channel | Direction | Handshake              | Word
// in      | input     | i_in_valid / o_in_stall  | rhd_pkg::t_in_word
// out     | output    | o_out_valid / i_out_stall| rhd_pkg::t_out_word
//
// One word is taken, then the lookahead window is decoded one step per cycle
// by a single decode unit while no byte is being emitted; each emitted byte
// leaves through the output register. The last word drains the window, and
// the terminator follows it.
// Reset is synchronous, active low, and needs no clearing pass.
// A stall on the output holds the sequencer in its emit or terminator state.
module rtf_html_deencapsulator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rhd_pkg::t_in_word   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rhd_pkg::t_out_word  o_out
);

    localparam int FW = rhd_pkg::FILL_W;
    localparam int TB = rhd_pkg::TAG_BITS;

    rhd_pkg::t_state  r_state, n_state;
    rhd_pkg::t_mode   r_mode, n_mode;
    rhd_pkg::t_window r_win;
    logic [FW-1:0]    r_fill;
    logic [TB-1:0]    r_tag, n_tag;
    logic [TB-1:0]    r_pend, n_pend;
    logic             r_pend_v, n_pend_v;
    logic             r_marker, n_marker;
    logic             r_drain;

    // Emit buffer filled by one decode step.
    logic [2:0][7:0]  r_ebuf, n_ebuf;
    logic [1:0]       r_ecnt, n_ecnt;
    logic [1:0]       r_eidx;

    logic             r_out_valid, n_out_valid;
    rhd_pkg::t_out_word r_out;

    logic [FW-1:0]    d_cons;
    logic             in_acc, slot_free, work;
    logic [7:0]       b;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign b         = r_win[0];
    assign work      = r_drain ? (r_fill != '0)
                               : (r_fill >= FW'(rhd_pkg::WINDOW_BYTES));

    // Single decode unit: one step of the parser on the current window.
    always_comb begin
        logic [FW-1:0] sp_n;
        logic [7:0]    hi, lo;
        logic          skip;
        n_mode   = r_mode;
        n_tag    = r_tag;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_marker = r_marker;
        n_ebuf   = r_ebuf;
        n_ecnt   = 2'd0;
        d_cons   = '0;
        sp_n     = '0;
        hi       = '0;
        lo       = '0;
        skip     = 1'b0;
        case (r_mode)
            rhd_pkg::MODE_SEEK: begin
                if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_HTMLTAG_OPEN, FW'(11)))
                    n_mode = rhd_pkg::MODE_NORMAL;
                else
                    d_cons = FW'(1);
            end
            rhd_pkg::MODE_TAGNUM: begin
                if (b >= "0" && b <= "9") begin
                    n_tag  = (r_tag << 3) + (r_tag << 1) + TB'(b - 8'd48);
                    d_cons = FW'(1);
                end else begin
                    if (b == " ")
                        d_cons = FW'(1);
                    if (r_marker) begin
                        n_pend   = r_tag;
                        n_pend_v = 1'b1;
                        n_mode   = rhd_pkg::MODE_NORMAL;
                    end else begin
                        skip     = r_pend_v && (r_pend == r_tag);
                        n_pend_v = 1'b0;
                        n_mode   = skip ? rhd_pkg::MODE_SKIPBRACE : rhd_pkg::MODE_NORMAL;
                    end
                end
            end
            rhd_pkg::MODE_SKIPBRACE: begin
                if (b == "}")
                    n_mode = rhd_pkg::MODE_NORMAL;
                d_cons = FW'(1);
            end
            rhd_pkg::MODE_DIGITS: begin
                if (b >= "0" && b <= "9") begin
                    d_cons = FW'(1);
                end else begin
                    if (b == " ")
                        d_cons = FW'(1);
                    n_mode = rhd_pkg::MODE_NORMAL;
                end
            end
            rhd_pkg::MODE_PNTEXT: begin
                if (b == "}")
                    n_mode = rhd_pkg::MODE_NORMAL;
                else
                    d_cons = FW'(1);
            end
            rhd_pkg::MODE_HTMLRTF: begin
                if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_HTMLRTF0, FW'(9))) begin
                    sp_n   = FW'(9);
                    n_mode = rhd_pkg::MODE_NORMAL;
                end else begin
                    d_cons = FW'(1);
                end
            end
            default: begin
                if (b == "{" || b == "}") begin
                    d_cons = FW'(1);
                end else if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_HTMLTAG, FW'(10))) begin
                    d_cons = FW'(10);
                    n_tag = '0; n_marker = 1'b0; n_mode = rhd_pkg::MODE_TAGNUM;
                end else if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_MHTMLTAG, FW'(11))) begin
                    d_cons = FW'(11);
                    n_tag = '0; n_marker = 1'b1; n_mode = rhd_pkg::MODE_TAGNUM;
                end else if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_PAR, FW'(4))) begin
                    n_ebuf[0] = 8'h0d; n_ebuf[1] = 8'h0a; n_ecnt = 2'd2;
                    sp_n = FW'(4);
                end else if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_TAB, FW'(4))) begin
                    n_ebuf = {3{8'h20}}; n_ecnt = 2'd3;
                    sp_n = FW'(4);
                end else if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_LINE, FW'(5))) begin
                    n_ebuf[0] = 8'h0d; n_ebuf[1] = 8'h0a; n_ecnt = 2'd2;
                    sp_n = FW'(5);
                end else if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_LI, FW'(3))) begin
                    d_cons = FW'(3); n_mode = rhd_pkg::MODE_DIGITS;
                end else if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_FI, FW'(4))) begin
                    d_cons = FW'(4); n_mode = rhd_pkg::MODE_DIGITS;
                end else if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_HEX, FW'(2))) begin
                    hi = rhd_pkg::f_hex(r_win[2], r_fill > FW'(2));
                    lo = rhd_pkg::f_hex(r_win[3], r_fill > FW'(3));
                    // high digit keeps its low nibble, low digit adds at full width
                    n_ebuf[0] = {hi[3:0], 4'h0} + lo; n_ecnt = 2'd1;
                    d_cons = FW'(4);
                end else if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_PNTEXT, FW'(7))) begin
                    d_cons = FW'(7); n_mode = rhd_pkg::MODE_PNTEXT;
                end else if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_HTMLRTF, FW'(8))) begin
                    d_cons = FW'(1); n_mode = rhd_pkg::MODE_HTMLRTF;
                end else if (b == 8'h0d || b == 8'h0a) begin
                    d_cons = FW'(1);
                end else if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_LBRACE, FW'(2))) begin
                    n_ebuf[0] = "{"; n_ecnt = 2'd1; d_cons = FW'(2);
                end else if (rhd_pkg::f_match(r_win, r_fill, rhd_pkg::P_RBRACE, FW'(2))) begin
                    n_ebuf[0] = "}"; n_ecnt = 2'd1; d_cons = FW'(2);
                end else begin
                    n_ebuf[0] = b; n_ecnt = 2'd1; d_cons = FW'(1);
                end
            end
        endcase
        // Swallow one trailing space after a control word.
        if (sp_n != '0) begin
            d_cons = sp_n;
            if (sp_n < r_fill && r_win[sp_n[rhd_pkg::IDX_W-1:0]] == " ")
                d_cons = sp_n + FW'(1);
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rhd_pkg::ST_IDLE: begin
                if (in_acc)
                    n_state = rhd_pkg::ST_DECIDE;
            end
            rhd_pkg::ST_DECIDE: begin
                if (!work)
                    n_state = r_drain ? rhd_pkg::ST_TERM : rhd_pkg::ST_IDLE;
                else if (n_ecnt != 2'd0)
                    n_state = rhd_pkg::ST_EMIT;
            end
            rhd_pkg::ST_EMIT: begin
                if (slot_free && (r_eidx + 2'd1 == r_ecnt))
                    n_state = rhd_pkg::ST_DECIDE;
            end
            rhd_pkg::ST_TERM: begin
                if (slot_free)
                    n_state = rhd_pkg::ST_IDLE;
            end
            default: n_state = rhd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall = (r_state != rhd_pkg::ST_IDLE);
        // a free slot loads a byte in emit or terminator states, else empties
        if (slot_free)
            n_out_valid = (r_state == rhd_pkg::ST_EMIT) || (r_state == rhd_pkg::ST_TERM);
        else
            n_out_valid = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rhd_pkg::ST_IDLE;
            r_mode      <= rhd_pkg::MODE_SEEK;
            r_fill      <= '0;
            r_tag       <= '0;
            r_pend      <= '0;
            r_pend_v    <= 1'b0;
            r_marker    <= 1'b0;
            r_drain     <= 1'b0;
            r_ecnt      <= '0;
            r_eidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            case (r_state)
                rhd_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_drain <= i_in.in_last;
                        if (r_fill < FW'(rhd_pkg::WINDOW_BYTES)) begin
                            r_win[r_fill[rhd_pkg::IDX_W-1:0]] <= i_in.in_byte;
                            r_fill <= r_fill + FW'(1);
                        end
                    end
                end
                rhd_pkg::ST_DECIDE: begin
                    if (work) begin
                        r_mode   <= n_mode;
                        r_tag    <= n_tag;
                        r_pend   <= n_pend;
                        r_pend_v <= n_pend_v;
                        r_marker <= n_marker;
                        r_ebuf   <= n_ebuf;
                        r_ecnt   <= n_ecnt;
                        r_eidx   <= '0;
                        if (d_cons >= r_fill)
                            r_fill <= '0;
                        else begin
                            r_fill <= r_fill - d_cons;
                            r_win  <= r_win >> {d_cons, 3'b000};
                        end
                    end
                end
                rhd_pkg::ST_EMIT: begin
                    if (slot_free) begin
                        r_out.out_byte <= r_ebuf[r_eidx];
                        r_out.out_last <= 1'b0;
                        r_eidx         <= r_eidx + 2'd1;
                    end
                end
                rhd_pkg::ST_TERM: begin
                    if (slot_free) begin
                        r_out.out_byte <= 8'h00;
                        r_out.out_last <= 1'b1;
                        // back to reset state for the next stream
                        r_mode   <= rhd_pkg::MODE_SEEK;
                        r_fill   <= '0;
                        r_tag    <= '0;
                        r_pend   <= '0;
                        r_pend_v <= 1'b0;
                        r_marker <= 1'b0;
                        r_drain  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/rhd_checker.sv
`include "rtf_html_deencapsulator_top_defines.svh"

module rhd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rhd_pkg::t_out_word o_out
);

    // a stalled word stays offered
    `RHD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n && o_out_valid && i_out_stall, o_out_valid)
    // an accepted word always raises the input stall
    `RHD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n && i_in_valid && !o_in_stall, o_in_stall)
    // terminator carries a zero byte
    `RHD_ASSERT_NOW(a_term_zero, i_clk, i_rst_n, o_out_valid && o_out.out_last, o_out.out_byte == 8'h00)
    // nothing offered right after reset
    `RHD_ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind rtf_html_deencapsulator_top rhd_checker u_rhd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
